// ===== design/pns_pkg.sv =====
// Shared constants, types and helpers of the pitch note segmenter.
package pns_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FRAME_BITS = 24;
    localparam int CENTS_W    = 20;
    localparam int F0_W       = 20;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [1:0] CFG_MIN_LEN   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_REFERENCE = 2'd2;
    localparam logic [1:0] CFG_HOP       = 2'd3;

    typedef enum logic {
        CMD_WRITE,
        CMD_NOTE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic [RING_AW-1:0]         addr;
        logic signed [CENTS_W-1:0]  cents;
        logic [FRAME_BITS-1:0]      start;
        logic [FRAME_BITS:0]        stop;
        logic                       last;
    } t_cmd;

    typedef struct packed {
        logic [9:0]      min_len;
        logic [15:0]     threshold;
        logic [F0_W-1:0] reference;
    } t_front_cfg;

    function automatic logic [4:0] f_lead(logic [F0_W-1:0] x);
        logic [4:0] e;
        e = '0;
        for (int i = 0; i < F0_W; i++) begin
            if (x[i]) begin
                e = 5'(i);
            end
        end
        return e;
    endfunction

endpackage

// ===== design/pns_front.sv =====
// Front end: accepts frames, converts pitch to cents and segments notes into commands.
module pns_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pns_pkg::t_front_cfg i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_voiced,
    input  logic [19:0]         i_f0,
    input  logic                i_last,
    output logic                o_push,
    output pns_pkg::t_cmd       o_cmd,
    input  logic                i_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG,
        S_MUL,
        S_DECIDE,
        S_PUSH
    } t_state;

    localparam logic [23:0] FRAME_MAX = {pns_pkg::FRAME_BITS{1'b1}};

    t_state               r_state;
    logic                 r_voiced;
    logic                 r_last;
    logic [4:0]           r_ef, r_er;
    logic [19:0]          r_mf, r_mr;
    logic [15:0]          r_ff, r_fr;
    logic [3:0]           r_step;
    logic signed [37:0]   r_v;
    logic                 r_open;
    logic [23:0]          r_start;
    logic [23:0]          r_fi;
    logic signed [19:0]   r_anchor;
    logic [9:0]           r_run;
    pns_pkg::t_cmd        r_cmd [3];
    logic [1:0]           r_ncmd;
    logic [1:0]           r_pidx;

    logic                 n_open;
    logic [23:0]          n_start;
    logic [23:0]          n_fi;
    logic signed [19:0]   n_anchor;
    logic [9:0]           n_run;
    pns_pkg::t_cmd        n_cmd [3];
    logic [1:0]           n_ncmd;

    logic [4:0]           w_ef, w_er;
    logic [39:0]          w_sqf, w_sqr;
    logic signed [21:0]   w_d;
    logic signed [19:0]   w_c;
    logic                 w_voiced;

    assign w_voiced = i_voiced && (i_f0 != '0);
    assign w_ef     = pns_pkg::f_lead(i_f0);
    assign w_er     = pns_pkg::f_lead(i_cfg.reference);
    assign w_sqf    = r_mf * r_mf;
    assign w_sqr    = r_mr * r_mr;
    assign w_d      = $signed({1'b0, r_ef, r_ff}) - $signed({1'b0, r_er, r_fr});
    assign w_c      = r_v[35:16];

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_cmd   = r_cmd[r_pidx];

    always_comb begin
        logic [9:0]         mf;
        logic [24:0]        mf25;
        logic signed [20:0] diff;
        logic [20:0]        dev;
        logic [9:0]         run_n;
        logic [23:0]        back;
        logic [23:0]        split;
        logic               has_note;
        logic [1:0]         lni;
        mf       = (i_cfg.min_len == '0) ? 10'd1 : i_cfg.min_len;
        mf25     = 25'(mf);
        n_open   = r_open;
        n_start  = r_start;
        n_anchor = r_anchor;
        n_run    = r_run;
        n_ncmd   = '0;
        has_note = 1'b0;
        lni      = '0;
        diff     = 21'(w_c) - 21'(r_anchor);
        dev      = diff[20] ? 21'(-diff) : 21'(diff);
        run_n    = r_run + 10'd1;
        back     = 24'(run_n - 10'd1);
        split    = (r_fi >= back) ? (r_fi - back) : '0;
        if (split < r_start) begin
            split = r_start;
        end
        for (int i = 0; i < 3; i++) begin
            n_cmd[i] = '0;
        end
        if (!r_voiced) begin
            if (r_open && (25'(r_fi) - 25'(r_start) >= mf25)) begin
                n_cmd[n_ncmd] = '{pns_pkg::CMD_NOTE, '0, '0, r_start, 25'(r_fi), 1'b0};
                has_note = 1'b1;
                lni = n_ncmd;
                n_ncmd = n_ncmd + 2'd1;
            end
            n_open = 1'b0;
            n_run  = '0;
        end else begin
            n_cmd[n_ncmd] = '{pns_pkg::CMD_WRITE, r_fi[pns_pkg::RING_AW-1:0], w_c,
                              '0, '0, 1'b0};
            n_ncmd = n_ncmd + 2'd1;
            if (!r_open) begin
                n_open   = 1'b1;
                n_start  = r_fi;
                n_anchor = w_c;
                n_run    = '0;
            end else if (dev > 21'(i_cfg.threshold)) begin
                n_run = run_n;
                if (run_n >= mf) begin
                    if (25'(split) - 25'(r_start) >= mf25) begin
                        n_cmd[n_ncmd] = '{pns_pkg::CMD_NOTE, '0, '0, r_start, 25'(split),
                                          1'b0};
                        has_note = 1'b1;
                        lni = n_ncmd;
                        n_ncmd = n_ncmd + 2'd1;
                    end
                    n_start  = split;
                    n_anchor = w_c;
                    n_run    = '0;
                end
            end else begin
                n_run = '0;
            end
            if (r_last) begin
                if (25'(r_fi) + 25'd1 - 25'(n_start) >= mf25) begin
                    n_cmd[n_ncmd] = '{pns_pkg::CMD_NOTE, '0, '0, n_start,
                                      25'(r_fi) + 25'd1, 1'b0};
                    has_note = 1'b1;
                    lni = n_ncmd;
                    n_ncmd = n_ncmd + 2'd1;
                end
                n_open = 1'b0;
                n_run  = '0;
            end
        end
        if (has_note) begin
            n_cmd[lni].last = 1'b1;
        end
        if (r_last) begin
            n_fi   = '0;
            n_open = 1'b0;
            n_run  = '0;
        end else if (r_fi < FRAME_MAX) begin
            n_fi = r_fi + 24'd1;
        end else begin
            n_fi = r_fi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= 1'b0;
            r_start  <= '0;
            r_fi     <= '0;
            r_anchor <= '0;
            r_run    <= '0;
            r_ncmd   <= '0;
            r_pidx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_voiced <= w_voiced;
                        r_last   <= i_last;
                        r_ef     <= (i_f0 == '0) ? 5'd0 : w_ef;
                        r_er     <= (i_cfg.reference == '0) ? 5'd0 : w_er;
                        r_mf     <= i_f0 << (5'd19 - w_ef);
                        r_mr     <= i_cfg.reference << (5'd19 - w_er);
                        r_ff     <= '0;
                        r_fr     <= '0;
                        r_step   <= '0;
                        r_v      <= '0;
                        r_state  <= w_voiced ? S_LOG : S_DECIDE;
                    end
                end
                S_LOG: begin
                    r_mf   <= w_sqf[39] ? w_sqf[39:20] : w_sqf[38:19];
                    r_mr   <= w_sqr[39] ? w_sqr[39:20] : w_sqr[38:19];
                    r_ff   <= {r_ff[14:0], w_sqf[39]};
                    r_fr   <= {r_fr[14:0], w_sqr[39]};
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_v     <= 38'(w_d) * 38'sd19200 + 38'sd32768;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_open   <= n_open;
                    r_start  <= n_start;
                    r_fi     <= n_fi;
                    r_anchor <= n_anchor;
                    r_run    <= n_run;
                    r_cmd    <= n_cmd;
                    r_ncmd   <= n_ncmd;
                    r_pidx   <= '0;
                    r_state  <= (n_ncmd == '0) ? S_IDLE : S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_pidx <= r_pidx + 2'd1;
                        if (r_pidx == r_ncmd - 2'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/pns_queue.sv =====
// Command queue between the front end and the back end.
module pns_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pns_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output pns_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    pns_pkg::t_cmd               r_mem [pns_pkg::Q_DEPTH];
    logic [pns_pkg::Q_AW-1:0]    r_wp, r_rp;
    logic [pns_pkg::Q_AW:0]      r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == (pns_pkg::Q_AW+1)'(pns_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/pns_back.sv =====
// Back end: cents ring, median selection by bisection, sample bounds and result register.
module pns_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_hop,
    input  pns_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [23:0]   o_start_frame,
    output logic [24:0]   o_end_frame,
    output logic [39:0]   o_start_sample,
    output logic [39:0]   o_end_sample,
    output logic [19:0]   o_median,
    output logic          o_truncated,
    output logic          o_last
);

    localparam int AW = pns_pkg::RING_AW;
    localparam logic [19:0] KEY_FLIP = 20'h80000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_MED,
        S_OUT
    } t_state;

    logic signed [19:0] r_ring [pns_pkg::RING_DEPTH];
    logic signed [19:0] r_rdata;

    t_state         r_state;
    logic [23:0]    r_start;
    logic [24:0]    r_stop;
    logic           r_lastf;
    logic           r_trunc;
    logic [AW:0]    r_k;
    logic [AW-1:0]  r_base;
    logic [AW-1:0]  r_rank;
    logic [4:0]     r_bit;
    logic [19:0]    r_ans;
    logic           r_extra;
    logic [AW:0]    r_idx;
    logic           r_rv;
    logic [AW:0]    r_cnt;
    logic [19:0]    r_min;
    logic [19:0]    r_a, r_b;
    logic [19:0]    r_med;
    logic           r_ovalid;

    logic [24:0]    w_len;
    logic           w_trunc;
    logic [AW:0]    w_k;
    logic [19:0]    w_t;
    logic [19:0]    w_key;
    logic [19:0]    w_nans;
    logic           w_done;
    logic           w_load;
    logic signed [20:0] w_sum;
    logic [AW-1:0]  w_raddr;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign w_len   = i_head.stop - 25'(i_head.start);
    assign w_trunc = w_len > 25'(pns_pkg::RING_DEPTH);
    assign w_k     = w_trunc ? (AW+1)'(pns_pkg::RING_DEPTH) : w_len[AW:0];
    assign w_t     = r_ans | (20'd1 << r_bit);
    assign w_key   = r_rdata ^ KEY_FLIP;
    assign w_nans  = (r_cnt <= (AW+1)'(r_rank)) ? w_t : r_ans;
    assign w_done  = (r_idx == r_k) && !r_rv;
    assign w_load  = (r_state == S_OUT) && (!r_ovalid || i_ready);
    assign w_sum   = 21'($signed(r_a ^ KEY_FLIP)) + 21'($signed(r_b ^ KEY_FLIP)) + 21'sd1;
    assign w_raddr = r_base + r_idx[AW-1:0];
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == pns_pkg::CMD_WRITE)) begin
            r_ring[i_head.addr] <= i_head.cents;
        end
        r_rdata <= r_ring[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_head.kind == pns_pkg::CMD_NOTE)) begin
                        r_start <= i_head.start;
                        r_stop  <= i_head.stop;
                        r_lastf <= i_head.last;
                        r_trunc <= w_trunc;
                        r_k     <= w_k;
                        r_base  <= i_head.stop[AW-1:0] - w_k[AW-1:0];
                        r_rank  <= AW'((w_k - (AW+1)'(1)) >> 1);
                        r_bit   <= 5'd19;
                        r_ans   <= '0;
                        r_extra <= 1'b0;
                        r_idx   <= '0;
                        r_rv    <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_rv <= (r_idx != r_k);
                    if (r_idx != r_k) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rv) begin
                        if (!r_extra) begin
                            if (w_key < w_t) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end else if (w_key <= r_a) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else if (w_key < r_min) begin
                            r_min <= w_key;
                        end
                    end
                    if (w_done) begin
                        r_idx <= '0;
                        r_cnt <= '0;
                        if (r_extra) begin
                            r_b     <= (r_cnt > (AW+1)'(r_rank) + 1'b1) ? r_a : r_min;
                            r_state <= S_MED;
                        end else begin
                            r_ans <= w_nans;
                            if (r_bit != '0) begin
                                r_bit <= r_bit - 5'd1;
                            end else if (!r_k[0]) begin
                                r_a     <= w_nans;
                                r_min   <= '1;
                                r_extra <= 1'b1;
                            end else begin
                                r_a     <= w_nans;
                                r_b     <= w_nans;
                                r_state <= S_MED;
                            end
                        end
                    end
                end
                S_MED: begin
                    r_med   <= w_sum[20:1];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        o_start_frame  <= r_start;
                        o_end_frame    <= r_stop;
                        o_start_sample <= 40'(r_start) * 40'(i_hop);
                        o_end_sample   <= 40'(r_stop) * 40'(i_hop);
                        o_median       <= r_med;
                        o_truncated    <= r_trunc;
                        o_last         <= r_lastf;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/pitch_note_segmenter_core.sv =====
// Top level of the pitch note segmenter: configuration registers and stream ports.
//
// channel   | dir | contents
// s_axis    | in  | tdata: f0_q8[19:0]; tuser: voiced; tlast: track_end
// m_axis    | out | tdata: start_frame, end_frame, start_sample, end_sample, median_cents
//           |     | tuser: truncated; tlast: last_of_run
// cfg       | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// A voiced frame holds the front end through 16 squaring steps of the log2 unit, the cents
// multiply, the decision and one push per queued command, each push waiting while the queue is
// full; an unvoiced frame skips the squaring steps and the multiply. A note holds the back end
// through 20 bisection passes, one ring read per cycle in each, one more pass for the upper middle
// value when k is even (k = note length capped at the ring depth), then the median and output steps.
// Reset is synchronous, active low; no clearing pass. The command queue lets the front
// end keep taking frames while a median is in progress, until four commands are pending.
module pitch_note_segmenter_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [23:0]   i_s_axis_tdata,   // f0_q8[19:0], zero pad
    input  logic          i_s_axis_tuser,   // voiced
    input  logic          i_s_axis_tlast,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [151:0]  o_m_axis_tdata,   // start_frame, end_frame, start_sample,
                                            // end_sample, median_cents, zero pad
    output logic          o_m_axis_tuser,   // truncated
    output logic          o_m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [19:0]   i_cfg_data
);

    pns_pkg::t_front_cfg r_cfg;
    logic [15:0]         r_hop;

    logic                w_push, w_pop, w_full, w_empty;
    pns_pkg::t_cmd       w_cmd, w_head;
    logic [23:0]         w_start_frame;
    logic [24:0]         w_end_frame;
    logic [39:0]         w_start_sample, w_end_sample;
    logic [19:0]         w_median;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len   <= 10'd1;
            r_cfg.threshold <= 16'd800;
            r_cfg.reference <= 20'd112640;
            r_hop           <= 16'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pns_pkg::CFG_MIN_LEN:   r_cfg.min_len   <= i_cfg_data[9:0];
                pns_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[15:0];
                pns_pkg::CFG_REFERENCE: r_cfg.reference <= i_cfg_data;
                pns_pkg::CFG_HOP:       r_hop           <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pns_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_voiced (i_s_axis_tuser),
        .i_f0     (i_s_axis_tdata[19:0]),
        .i_last   (i_s_axis_tlast),
        .o_push   (w_push),
        .o_cmd    (w_cmd),
        .i_full   (w_full)
    );

    pns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pns_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hop          (r_hop),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_start_frame  (w_start_frame),
        .o_end_frame    (w_end_frame),
        .o_start_sample (w_start_sample),
        .o_end_sample   (w_end_sample),
        .o_median       (w_median),
        .o_truncated    (o_m_axis_tuser),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, w_median, w_end_sample, w_start_sample,
                             w_end_frame, w_start_frame};

endmodule
